>>> src/mst_pkg.sv
// mst_pkg: shared types and constants for the multi-slot periodic timer table.
// No dependencies; used by every module under src.
`default_nettype none

package mst_pkg;

  // Most fire results one dispatch may return.
  localparam int MaxRes = 8;
  localparam int ResCntW = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REG  = 2'd1,
    OP_DEL  = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_TICK_DONE  = 3'd0,
    K_REGISTERED = 3'd1,
    K_FULL       = 3'd2,
    K_DELETED    = 3'd3,
    K_FIRE       = 3'd4,
    K_NONE       = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  slot;
    logic [31:0] period;
    logic [15:0] run_count;
    logic        repeat_forever;
    logic [7:0]  user_tag;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] slot_index;
    logic [7:0] fire_count;
    logic [7:0] tag_out;
    logic       expired;
    logic       last;
  } out_item_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t         op;
    logic [2:0]  slot;
    logic        del_hit;
    logic [31:0] period;
    logic [15:0] run_count;
    logic        keep_forever;
    logic [7:0]  tag;
  } cmd_t;

  // One slot-RAM record.
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] countdown;
    logic [15:0] remaining;
    logic        keep_forever;
    logic [7:0]  pending;
    logic [7:0]  tag;
  } slot_rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TICK,
    BK_REG,
    BK_DEL,
    BK_DISP
  } bk_state_t;

endpackage

`default_nettype wire

>>> src/mst_front.sv
// mst_front: accepts input items and classifies them into commands.
// Depends on mst_pkg; feeds mst_cmdq.
`default_nettype none

module mst_front #(
  parameter int SLOTS = 8
) (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mst_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   push,
  output mst_pkg::cmd_t          cmd
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.op           = mst_pkg::op_t'(in_data.opcode);
    cmd.slot         = in_data.slot;
    // delete only names slots that exist
    cmd.del_hit      = ({5'd0, in_data.slot} < 8'(SLOTS));
    cmd.period       = in_data.period;
    cmd.run_count    = in_data.run_count;
    cmd.keep_forever = in_data.repeat_forever;
    cmd.tag          = in_data.user_tag;
  end

endmodule

`default_nettype wire

>>> src/mst_cmdq.sv
// mst_cmdq: two-entry command queue between front and back.
// Depends on mst_pkg.
`default_nettype none

module mst_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mst_pkg::cmd_t cmd_in,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output mst_pkg::cmd_t      cmd_out
);

  mst_pkg::cmd_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign cmd_out = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> src/mst_back.sv
// mst_back: executes commands against the slot RAM, one slot per cycle
// while not stalled, and drives the output register. Depends on mst_pkg.
`default_nettype none

module mst_back #(
  parameter int SLOTS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire mst_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mst_pkg::out_item_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = mst_pkg::ResCntW;

  mst_pkg::bk_state_t state_r, state_nxt;
  mst_pkg::cmd_t      cmd_r;

  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               s1_v_r, s1_v_nxt;
  logic [IW-1:0]      s1_idx_r, s1_idx_nxt;
  logic [RW-1:0]      n_res_r, n_res_nxt;
  logic               hold_v_r, hold_v_nxt;
  mst_pkg::out_item_t hold_r, hold_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic               out_v_r;
  mst_pkg::out_item_t out_r;

  mst_pkg::slot_rec_t mem [SLOTS];
  mst_pkg::slot_rec_t rd_data_r;

  logic               go, walk_more, room, issue;
  logic [IW-1:0]      rd_addr;
  logic               tick_done, disp_done, reg_free, reg_end;
  logic               res_v;
  mst_pkg::out_item_t res;
  logic               we;
  logic [IW-1:0]      wa;
  mst_pkg::slot_rec_t wd;

  function automatic mst_pkg::slot_rec_t tick_upd(mst_pkg::slot_rec_t r);
    mst_pkg::slot_rec_t t;
    logic [31:0]        cd;
    t  = r;
    cd = (r.countdown != 32'd0) ? (r.countdown - 32'd1) : r.countdown;
    if (cd == 32'd0) begin
      if (r.pending != 8'hFF) begin
        t.pending = r.pending + 8'd1;
      end
      cd = r.period;
    end
    t.countdown = cd;
    return t;
  endfunction

  assign go        = !out_v_r || !out_stall;
  assign walk_more = (rd_idx_r < CW'(SLOTS));
  assign rd_addr   = rd_idx_r[IW-1:0];
  assign room      = (n_res_r < RW'(mst_pkg::MaxRes));
  assign issue     = go && walk_more &&
                     ((state_r == mst_pkg::BK_TICK) ||
                      ((state_r == mst_pkg::BK_DISP) && room));
  assign tick_done = (state_r == mst_pkg::BK_TICK) && !walk_more && !s1_v_r;
  assign disp_done = (state_r == mst_pkg::BK_DISP) && !s1_v_r && (!walk_more || !room);
  assign reg_free  = walk_more && !valid_r[rd_addr];
  assign reg_end   = (state_r == mst_pkg::BK_REG) && (reg_free || !walk_more);
  assign q_pop     = (state_r == mst_pkg::BK_IDLE) && q_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mst_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            mst_pkg::OP_TICK: state_nxt = mst_pkg::BK_TICK;
            mst_pkg::OP_REG:  state_nxt = mst_pkg::BK_REG;
            mst_pkg::OP_DEL:  state_nxt = mst_pkg::BK_DEL;
            mst_pkg::OP_DISP: state_nxt = mst_pkg::BK_DISP;
            default:          state_nxt = mst_pkg::BK_IDLE;
          endcase
        end
      end
      mst_pkg::BK_TICK: if (go && tick_done) state_nxt = mst_pkg::BK_IDLE;
      mst_pkg::BK_REG:  if (go && reg_end)   state_nxt = mst_pkg::BK_IDLE;
      mst_pkg::BK_DEL:  if (go)              state_nxt = mst_pkg::BK_IDLE;
      mst_pkg::BK_DISP: if (go && disp_done) state_nxt = mst_pkg::BK_IDLE;
      default:          state_nxt = mst_pkg::BK_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    logic [7:0]  fired;
    logic [15:0] rem;
    logic        exp;
    rd_idx_nxt = rd_idx_r;
    s1_v_nxt   = s1_v_r;
    s1_idx_nxt = s1_idx_r;
    n_res_nxt  = n_res_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    valid_nxt  = valid_r;
    res_v      = 1'b0;
    res        = '0;
    res.kind   = mst_pkg::K_TICK_DONE;
    we         = 1'b0;
    wa         = s1_idx_r;
    wd         = rd_data_r;
    fired      = rd_data_r.pending;
    rem        = rd_data_r.remaining;
    exp        = 1'b0;
    unique case (state_r)
      mst_pkg::BK_IDLE: begin
        if (q_valid) begin
          rd_idx_nxt = '0;
          s1_v_nxt   = 1'b0;
          n_res_nxt  = '0;
          hold_v_nxt = 1'b0;
        end
      end
      mst_pkg::BK_TICK: begin
        if (go) begin
          s1_v_nxt   = walk_more;
          s1_idx_nxt = rd_addr;
          if (walk_more) rd_idx_nxt = rd_idx_r + CW'(1);
          if (s1_v_r && valid_r[s1_idx_r]) begin
            we = 1'b1;
            wd = tick_upd(rd_data_r);
          end
          if (tick_done) begin
            res_v    = 1'b1;
            res.kind = mst_pkg::K_TICK_DONE;
            res.last = 1'b1;
          end
        end
      end
      mst_pkg::BK_DISP: begin
        if (go) begin
          s1_v_nxt   = walk_more && room;
          s1_idx_nxt = rd_addr;
          if (walk_more && room) rd_idx_nxt = rd_idx_r + CW'(1);
          if (s1_v_r && room && valid_r[s1_idx_r] && (rd_data_r.pending != 8'd0)) begin
            if (!rd_data_r.keep_forever) begin
              if ({8'd0, fired} > rem) fired = rem[7:0];
              rem = rem - {8'd0, fired};
              exp = (rem == 16'd0);
            end
            we           = 1'b1;
            wd.remaining = rem;
            wd.pending   = 8'd0;
            if (exp) valid_nxt[s1_idx_r] = 1'b0;
            n_res_nxt = n_res_r + RW'(1);
            // previous fire goes out now that a later one exists
            if (hold_v_r) begin
              res_v = 1'b1;
              res   = hold_r;
            end
            hold_v_nxt          = 1'b1;
            hold_nxt            = '0;
            hold_nxt.kind       = mst_pkg::K_FIRE;
            hold_nxt.slot_index = 3'(s1_idx_r);
            hold_nxt.fire_count = fired;
            hold_nxt.tag_out    = rd_data_r.tag;
            hold_nxt.expired    = exp;
          end
          if (disp_done) begin
            res_v = 1'b1;
            if (hold_v_r) begin
              res = hold_r;
            end else begin
              res.kind = mst_pkg::K_NONE;
            end
            res.last   = 1'b1;
            hold_v_nxt = 1'b0;
          end
        end
      end
      mst_pkg::BK_REG: begin
        if (go) begin
          if (reg_end) begin
            res_v    = 1'b1;
            res.last = 1'b1;
            if (reg_free) begin
              we                 = 1'b1;
              wa                 = rd_addr;
              wd.period          = cmd_r.period;
              wd.countdown       = cmd_r.period;
              wd.remaining       = cmd_r.run_count;
              wd.keep_forever    = cmd_r.keep_forever;
              wd.pending         = 8'd0;
              wd.tag             = cmd_r.tag;
              valid_nxt[rd_addr] = 1'b1;
              res.kind           = mst_pkg::K_REGISTERED;
              res.slot_index     = 3'(rd_addr);
            end else begin
              res.kind = mst_pkg::K_FULL;
            end
          end else begin
            rd_idx_nxt = rd_idx_r + CW'(1);
          end
        end
      end
      mst_pkg::BK_DEL: begin
        if (go) begin
          res_v          = 1'b1;
          res.kind       = mst_pkg::K_DELETED;
          res.slot_index = cmd_r.slot;
          res.last       = 1'b1;
          if (cmd_r.del_hit) valid_nxt[IW'(cmd_r.slot)] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mst_pkg::BK_IDLE;
      rd_idx_r <= '0;
      s1_v_r   <= 1'b0;
      n_res_r  <= '0;
      hold_v_r <= 1'b0;
      valid_r  <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      s1_v_r   <= s1_v_nxt;
      n_res_r  <= n_res_nxt;
      hold_v_r <= hold_v_nxt;
      valid_r  <= valid_nxt;
      if (go) out_v_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= s1_idx_nxt;
    hold_r   <= hold_nxt;
    if (q_pop) cmd_r <= q_cmd;
    if (go && res_v) out_r <= res;
  end

  // slot RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (issue) rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> src/multi_slot_periodic_timer_table_top.sv
// Multi-slot periodic timer table, top level. Depends on mst_pkg, mst_front,
// mst_cmdq and mst_back. Tick and dispatch walk the slot RAM, one slot RAM
// read per cycle while the output is not stalled; the back works on one
// command at a time while the queue holds up to two more.
// Reset (rst_n low, synchronous) frees every slot and empties the queue.
`default_nettype none

module multi_slot_periodic_timer_table_top #(
  parameter int SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input item channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mst_pkg::in_item_t in_data,
  // result item channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mst_pkg::out_item_t     out_data
);

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  mst_pkg::cmd_t f_cmd;
  mst_pkg::cmd_t q_cmd;

  // Front: takes the item, decodes the opcode, checks the delete index.
  mst_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .push    (push),
    .cmd     (f_cmd)
  );

  // Two-entry queue so the front keeps taking items while the back walks.
  mst_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (f_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .q_valid(q_valid),
    .cmd_out(q_cmd)
  );

  // Back: slot RAM sequencer plus output register; stalls on out_stall.
  mst_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for multi_slot_periodic_timer_table_top.
// Holds its own model of the timer slots to predict every result item and
// compares the block's output with it. Depends on mst_pkg and the RTL under src.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_SLOTS = 8;

  // Scoreboard: a copy of the slot table plus the queue of result items
  // the block still owes.
  class timer_table_board;
    logic                 live      [NUM_SLOTS];
    logic [31:0]          reload    [NUM_SLOTS];
    logic [31:0]          count_left[NUM_SLOTS];
    logic [15:0]          runs_left [NUM_SLOTS];
    logic                 endless   [NUM_SLOTS];
    logic [7:0]           due       [NUM_SLOTS];
    logic [7:0]           tag       [NUM_SLOTS];
    mst_pkg::out_item_t   due_reports[$];
    int                   mismatches;

    function new();
      mismatches = 0;
      foreach (live[i]) begin
        live[i]       = 1'b0;
        reload[i]     = '0;
        count_left[i] = '0;
        runs_left[i]  = '0;
        endless[i]    = 1'b0;
        due[i]        = '0;
        tag[i]        = '0;
      end
    endfunction

    function void add(mst_pkg::kind_t k, int idx, int cnt, logic [7:0] t, logic gone);
      mst_pkg::out_item_t r;
      r            = '0;
      r.kind       = k;
      r.slot_index = idx[2:0];
      r.fire_count = cnt[7:0];
      r.tag_out    = t;
      r.expired    = gone;
      due_reports.push_back(r);
    endfunction

    // Apply one accepted command to the slot table and queue its results.
    function void note_command(mst_pkg::in_item_t cmd);
      mst_pkg::out_item_t r;
      int                 i;
      int                 found;
      int                 fired;
      int                 n;
      logic               gone;
      found = -1;
      n     = 0;
      case (mst_pkg::op_t'(cmd.opcode))
        mst_pkg::OP_TICK: begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (live[i]) begin
              if (count_left[i] != 0) count_left[i] = count_left[i] - 32'd1;
              if (count_left[i] == 0) begin
                if (due[i] != 8'hFF) due[i] = due[i] + 8'd1;
                count_left[i] = reload[i];
              end
            end
          end
          add(mst_pkg::K_TICK_DONE, 0, 0, 8'h00, 1'b0);
        end
        mst_pkg::OP_REG: begin
          for (i = 0; i < NUM_SLOTS && found < 0; i++)
            if (!live[i]) found = i;
          if (found < 0) begin
            add(mst_pkg::K_FULL, 0, 0, 8'h00, 1'b0);
          end else begin
            reload[found]     = cmd.period;
            count_left[found] = cmd.period;
            runs_left[found]  = cmd.run_count;
            endless[found]    = cmd.repeat_forever;
            due[found]        = '0;
            tag[found]        = cmd.user_tag;
            live[found]       = 1'b1;
            add(mst_pkg::K_REGISTERED, found, 0, 8'h00, 1'b0);
          end
        end
        mst_pkg::OP_DEL: begin
          if (cmd.slot < NUM_SLOTS) live[cmd.slot] = 1'b0;
          add(mst_pkg::K_DELETED, int'(cmd.slot), 0, 8'h00, 1'b0);
        end
        default: begin
          for (i = 0; i < NUM_SLOTS && n < mst_pkg::MaxRes; i++) begin
            if (live[i] && due[i] != 0) begin
              fired = int'(due[i]);
              gone  = 1'b0;
              if (!endless[i]) begin
                if (fired > int'(runs_left[i])) fired = int'(runs_left[i]);
                runs_left[i] = runs_left[i] - fired[15:0];
                if (runs_left[i] == 0) begin
                  gone    = 1'b1;
                  live[i] = 1'b0;
                end
              end
              due[i] = '0;
              add(mst_pkg::K_FIRE, i, fired, tag[i], gone);
              n++;
            end
          end
          if (n == 0) add(mst_pkg::K_NONE, 0, 0, 8'h00, 1'b0);
        end
      endcase
      // final result of this command carries last
      r      = due_reports.pop_back();
      r.last = 1'b1;
      due_reports.push_back(r);
    endfunction

    function void check_report(mst_pkg::out_item_t got);
      mst_pkg::out_item_t want;
      logic               bad;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d slot=%0d fires=%0d tag=%0h",
                   $time, got.kind, got.slot_index, got.fire_count, got.tag_out);
        return;
      end
      want = due_reports.pop_front();
      bad  = (got.kind !== want.kind) || (got.slot_index !== want.slot_index) ||
             (got.fire_count !== want.fire_count) || (got.tag_out !== want.tag_out) ||
             (got.expired !== want.expired) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected kind=%0d slot=%0d fires=%0d tag=%0h exp=%0b last=%0b",
                   $time, want.kind, want.slot_index, want.fire_count, want.tag_out,
                   want.expired, want.last);
          $display("%0t:          actual   kind=%0d slot=%0d fires=%0d tag=%0h exp=%0b last=%0b",
                   $time, got.kind, got.slot_index, got.fire_count, got.tag_out,
                   got.expired, got.last);
        end
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  mst_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mst_pkg::out_item_t out_data;

  // no_idle: both sides run without gaps; hold_off_req: receiver holds off
  // for a long stretch so the block backs up into its input.
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  timer_table_board board;

  multi_slot_periodic_timer_table_top #(
    .SLOTS(NUM_SLOTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_draw();
    return no_idle ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Send one item: optional gap with valid low, then hold valid and the
  // payload steady until an edge with stall low takes it. Valid stays high
  // after acceptance so back-to-back items never drop it within a step.
  task automatic push_command(mst_pkg::in_item_t cmd);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(cmd);
  endtask

  task automatic issue(mst_pkg::op_t op, int slot, logic [31:0] per, int runs,
                       bit forever_flag, int utag);
    mst_pkg::in_item_t cmd;
    cmd.opcode         = op;
    cmd.slot           = slot[2:0];
    cmd.period         = per;
    cmd.run_count      = runs[15:0];
    cmd.repeat_forever = forever_flag;
    cmd.user_tag       = utag[7:0];
    push_command(cmd);
  endtask

  // Sender pause: drop valid and wait for every owed result item.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_reports.size() != 0);
  endtask

  // Random command, biased toward short periods and few runs so slots
  // actually fire and expire; a minority of long periods and wide run counts.
  function automatic mst_pkg::in_item_t random_command();
    mst_pkg::in_item_t cmd;
    int                pick;
    int                sel;
    int                live_idx[$];
    cmd.slot           = 3'($urandom_range(0, 7));
    cmd.period         = $urandom;
    cmd.run_count      = 16'($urandom_range(0, 16'hFFFF));
    cmd.repeat_forever = 1'($urandom_range(0, 1));
    cmd.user_tag       = 8'($urandom_range(0, 255));
    pick = int'($urandom_range(0, 99));
    if (pick < 40) begin
      cmd.opcode = mst_pkg::OP_TICK;
    end else if (pick < 62) begin
      cmd.opcode = mst_pkg::OP_REG;
      sel = int'($urandom_range(0, 9));
      if (sel < 7) cmd.period = $urandom_range(0, 4);
      else if (sel < 9) cmd.period = $urandom_range(5, 20);
      sel = int'($urandom_range(0, 9));
      if (sel < 7) cmd.run_count = 16'($urandom_range(1, 4));
      else if (sel == 9) cmd.run_count = '0;
      cmd.repeat_forever = ($urandom_range(0, 3) == 0);
    end else if (pick < 74) begin
      cmd.opcode = mst_pkg::OP_DEL;
      foreach (board.live[i])
        if (board.live[i]) live_idx.push_back(i);
      if (live_idx.size() > 0 && $urandom_range(0, 3) != 0)
        cmd.slot = 3'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
    end else begin
      cmd.opcode = mst_pkg::OP_DISP;
    end
    return cmd;
  endfunction

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_report(out_data);
  end

  // Receiver: per result item a random hold-off, or one long hold when asked.
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        hold = idle_draw();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Main stimulus
  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table answers, zero period, widest period and run
    // count, zero run count, forever slot, excess pending, full table,
    // delete of a free slot and of a slot holding pending fires.
    issue(mst_pkg::OP_DISP, 0, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_TICK, 0, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_DEL, 5, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_REG, 0, 32'd0, 3, 1'b0, 'hA5);
    issue(mst_pkg::OP_REG, 7, 32'hFFFF_FFFF, 'hFFFF, 1'b0, 'h00);
    issue(mst_pkg::OP_REG, 0, 32'd1, 0, 1'b0, 'hFF);
    issue(mst_pkg::OP_REG, 0, 32'd2, 1, 1'b1, 'h5A);
    issue(mst_pkg::OP_REG, 0, 32'd0, 2, 1'b0, 'h3C);
    for (int k = 5; k < 8; k++) issue(mst_pkg::OP_REG, 0, 32'd3, 2, 1'b0, k);
    issue(mst_pkg::OP_REG, 0, 32'd4, 1, 1'b0, 'h11);
    repeat (3) issue(mst_pkg::OP_TICK, 0, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_DEL, 6, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_DISP, 0, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_DEL, 1, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_REG, 0, 32'd1, 1, 1'b0, 'h77);
    issue(mst_pkg::OP_TICK, 0, 32'd0, 0, 1'b0, 0);
    issue(mst_pkg::OP_DISP, 0, 32'd0, 0, 1'b0, 0);
    drain();

    // Random traffic in chunks; third chunk runs without idling, and a
    // back-pressure burst sits between the second and third.
    for (int chunk = 0; chunk < 4; chunk++) begin
      if (chunk == 2) begin
        hold_off_req = 1'b1;
        no_idle      = 1'b1;
        repeat (12) push_command(random_command());
        drain();
      end
      no_idle = (chunk == 2);
      repeat (22) push_command(random_command());
      no_idle = 1'b0;
      drain();
    end

    // settle time for stray results
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.due_reports.size() == 0) begin
      $display("PASS multi_slot_periodic_timer_table_top");
    end else begin
      $display("FAIL multi_slot_periodic_timer_table_top");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL multi_slot_periodic_timer_table_top");
    $finish;
  end

endmodule

>>> sim.f
src/mst_pkg.sv
src/mst_front.sv
src/mst_cmdq.sv
src/mst_back.sv
src/multi_slot_periodic_timer_table_top.sv
dv/testbench.sv
